// ===== rtl/scsu_pkg.sv =====
// shared types and constants for the sorted column set update block
// holds the transfer payload structs and the controller/datapath command and status structs
// no dependencies
package scsu_pkg;

    localparam int unsigned CAPACITY_DEF = 128;
    localparam int unsigned COL_W        = 15;
    localparam int unsigned RIDX_W       = 7;
    localparam int unsigned TOTAL_W      = 8;

    // operation codes carried in the func field
    localparam logic [1:0] FUNC_SINGLE = 2'd0;
    localparam logic [1:0] FUNC_RANGE  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic              set_not_clear;
        logic [COL_W-1:0]  column;
        logic [COL_W-1:0]  end_column;
        logic [COL_W-1:0]  interval;
        logic [RIDX_W-1:0] read_index;
    } scsu_cmd_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] stop_total;
        logic               changed;
        logic               overflow;
        logic               read_valid;
        logic [COL_W-1:0]   read_column;
    } scsu_rsp_t;

    // memory read address source
    typedef enum logic [1:0] {
        RD_FIRST,
        RD_NEXT,
        RD_PICK
    } scsu_rd_sel_t;

    // memory write address source
    typedef enum logic [1:0] {
        WA_PTR,
        WA_PREV,
        WA_COUNT
    } scsu_wa_sel_t;

    // memory write data source
    typedef enum logic [1:0] {
        WD_COL,
        WD_CARRY,
        WD_FETCH
    } scsu_wd_sel_t;

    typedef struct packed {
        logic         load;
        logic         ptr_clr;
        logic         ptr_inc;
        logic         rd_en;
        scsu_rd_sel_t rd_sel;
        logic         wr_en;
        scsu_wa_sel_t wa_sel;
        scsu_wd_sel_t wd_sel;
        logic         carry_load;
        logic         count_inc;
        logic         count_dec;
        logic         mark_changed;
        logic         mark_overflow;
        logic         col_step;
        logic         read_take;
        logic         rsp_load;
    } scsu_ctl_t;

    typedef struct packed {
        logic [1:0] func;
        logic       set_not_clear;
        logic       cmp_lt;
        logic       cmp_eq;
        logic       ptr_last;
        logic       ptr_at_count;
        logic       count_zero;
        logic       full;
        logic       range_empty;
        logic       range_last;
        logic       ridx_ok;
    } scsu_sts_t;

endpackage

// ===== rtl/scsu_dp.sv =====
// datapath: stop list memory, count, scan pointer, carry, operand and result registers
// depends on scsu_pkg
module scsu_dp #(
    parameter int unsigned CAPACITY = scsu_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  scsu_pkg::scsu_cmd_t cmd,
    input  scsu_pkg::scsu_ctl_t ctl,
    output scsu_pkg::scsu_sts_t sts,
    output scsu_pkg::scsu_rsp_t rsp
);
    import scsu_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = (CW > RIDX_W) ? CW : RIDX_W;

    logic [COL_W-1:0]  mem [CAPACITY];

    logic [COL_W-1:0]  rd_data_reg;
    logic [COL_W-1:0]  carry_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     ptr_reg;

    logic [1:0]        func_reg;
    logic              set_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  end_reg;
    logic [COL_W-1:0]  step_reg;
    logic [RIDX_W-1:0] ridx_reg;

    logic              changed_reg;
    logic              overflow_reg;
    logic              rvalid_reg;
    logic [COL_W-1:0]  rcol_reg;
    scsu_rsp_t         rsp_reg;

    logic [CW:0]       ptr_plus;
    logic [CW-1:0]     ptr_prev;
    logic              next_ok;
    logic              rd_fire;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [COL_W-1:0]  wr_data;
    logic [COL_W:0]    col_sum;

    assign ptr_plus = {1'b0, ptr_reg} + {{CW{1'b0}}, 1'b1};
    assign ptr_prev = ptr_reg - {{(CW-1){1'b0}}, 1'b1};
    assign next_ok  = ptr_plus < {1'b0, count_reg};
    assign col_sum  = {1'b0, col_reg} + {1'b0, step_reg};

    always_comb
    begin
        case (ctl.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_NEXT:  rd_addr = ptr_plus[AW-1:0];
            RD_PICK:  rd_addr = AW'(ridx_reg);
            default:  rd_addr = '0;
        endcase
    end

    // a look-ahead read beyond the held entries is dropped
    assign rd_fire = ctl.rd_en && ((ctl.rd_sel != RD_NEXT) || next_ok);

    always_comb
    begin
        case (ctl.wa_sel)
            WA_PTR:   wr_addr = ptr_reg[AW-1:0];
            WA_PREV:  wr_addr = ptr_prev[AW-1:0];
            WA_COUNT: wr_addr = count_reg[AW-1:0];
            default:  wr_addr = ptr_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        case (ctl.wd_sel)
            WD_COL:   wr_data = col_reg;
            WD_CARRY: wr_data = carry_reg;
            WD_FETCH: wr_data = rd_data_reg;
            default:  wr_data = col_reg;
        endcase
    end

    // list memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_fire)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.count_inc)
        begin
            count_reg <= count_reg + {{(CW-1){1'b0}}, 1'b1};
        end
        else if (ctl.count_dec)
        begin
            count_reg <= count_reg - {{(CW-1){1'b0}}, 1'b1};
        end
    end

    // operands, pointer, carry, per-item flags and response register
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            func_reg     <= cmd.func;
            set_reg      <= cmd.set_not_clear;
            col_reg      <= cmd.column;
            end_reg      <= cmd.end_column;
            step_reg     <= cmd.interval;
            ridx_reg     <= cmd.read_index;
            changed_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            rvalid_reg   <= 1'b0;
            rcol_reg     <= '0;
        end
        else
        begin
            if (ctl.col_step)
            begin
                col_reg <= col_sum[COL_W-1:0];
            end
            if (ctl.mark_changed)
            begin
                changed_reg <= 1'b1;
            end
            if (ctl.mark_overflow)
            begin
                overflow_reg <= 1'b1;
            end
            if (ctl.read_take)
            begin
                rvalid_reg <= 1'b1;
                rcol_reg   <= rd_data_reg;
            end
        end

        if (ctl.ptr_clr)
        begin
            ptr_reg <= '0;
        end
        else if (ctl.ptr_inc)
        begin
            ptr_reg <= ptr_plus[CW-1:0];
        end

        if (ctl.carry_load)
        begin
            carry_reg <= rd_data_reg;
        end

        if (ctl.rsp_load)
        begin
            rsp_reg.stop_total  <= TOTAL_W'(count_reg);
            rsp_reg.changed     <= changed_reg;
            rsp_reg.overflow    <= overflow_reg;
            rsp_reg.read_valid  <= rvalid_reg;
            rsp_reg.read_column <= rcol_reg;
        end
    end

    assign sts.func          = func_reg;
    assign sts.set_not_clear = set_reg;
    assign sts.cmp_lt        = rd_data_reg < col_reg;
    assign sts.cmp_eq        = rd_data_reg == col_reg;
    assign sts.ptr_last      = ptr_plus == {1'b0, count_reg};
    assign sts.ptr_at_count  = ptr_reg == count_reg;
    assign sts.count_zero    = count_reg == '0;
    assign sts.full          = count_reg == CW'(CAPACITY);
    assign sts.range_empty   = col_reg > end_reg;
    assign sts.range_last    = (step_reg == '0) || (col_sum > {1'b0, end_reg});
    assign sts.ridx_ok       = IW'(ridx_reg) < IW'(count_reg);

    assign rsp = rsp_reg;

endmodule

// ===== rtl/scsu_ctrl.sv =====
// controller state machine: sequences the scan, insert and delete passes and the handshakes
// depends on scsu_pkg
module scsu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  scsu_pkg::scsu_sts_t sts,
    output scsu_pkg::scsu_ctl_t ctl
);
    import scsu_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DISPATCH = 9'b000000010,
        ST_START    = 9'b000000100,
        ST_SCAN     = 9'b000001000,
        ST_INS      = 9'b000010000,
        ST_DEL      = 9'b000100000,
        ST_NEXT     = 9'b001000000,
        ST_READ     = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_free;

    assign cmd_stall = state_reg != ST_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                case (sts.func)
                    FUNC_SINGLE: state_next = ST_START;
                    FUNC_RANGE:  state_next = sts.range_empty ? ST_DONE : ST_START;
                    FUNC_READ:
                    begin
                        if (sts.ridx_ok)
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = RD_PICK;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:     state_next = ST_DONE;
                endcase
            end

            // one column: empty list handled at once, otherwise start scan at entry 0
            ST_START:
            begin
                if (sts.count_zero)
                begin
                    if (sts.set_not_clear)
                    begin
                        ctl.wr_en        = 1'b1;
                        ctl.wa_sel       = WA_COUNT;
                        ctl.wd_sel       = WD_COL;
                        ctl.count_inc    = 1'b1;
                        ctl.mark_changed = 1'b1;
                    end
                    state_next = ST_NEXT;
                end
                else
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_sel  = RD_FIRST;
                    ctl.ptr_clr = 1'b1;
                    state_next  = ST_SCAN;
                end
            end

            // fetched entry at the pointer compared against the column
            ST_SCAN:
            begin
                if (sts.cmp_lt)
                begin
                    if (sts.ptr_last)
                    begin
                        if (sts.set_not_clear)
                        begin
                            if (sts.full)
                            begin
                                ctl.mark_overflow = 1'b1;
                            end
                            else
                            begin
                                ctl.wr_en        = 1'b1;
                                ctl.wa_sel       = WA_COUNT;
                                ctl.wd_sel       = WD_COL;
                                ctl.count_inc    = 1'b1;
                                ctl.mark_changed = 1'b1;
                            end
                        end
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        ctl.rd_en   = 1'b1;
                        ctl.rd_sel  = RD_NEXT;
                        ctl.ptr_inc = 1'b1;
                    end
                end
                else if (sts.cmp_eq)
                begin
                    if (sts.set_not_clear)
                    begin
                        state_next = ST_NEXT;
                    end
                    else if (sts.ptr_last)
                    begin
                        ctl.count_dec    = 1'b1;
                        ctl.mark_changed = 1'b1;
                        state_next       = ST_NEXT;
                    end
                    else
                    begin
                        ctl.rd_en   = 1'b1;
                        ctl.rd_sel  = RD_NEXT;
                        ctl.ptr_inc = 1'b1;
                        state_next  = ST_DEL;
                    end
                end
                else
                begin
                    if (!sts.set_not_clear)
                    begin
                        state_next = ST_NEXT;
                    end
                    else if (sts.full)
                    begin
                        ctl.mark_overflow = 1'b1;
                        state_next        = ST_NEXT;
                    end
                    else
                    begin
                        ctl.wr_en      = 1'b1;
                        ctl.wa_sel     = WA_PTR;
                        ctl.wd_sel     = WD_COL;
                        ctl.carry_load = 1'b1;
                        ctl.rd_en      = 1'b1;
                        ctl.rd_sel     = RD_NEXT;
                        ctl.ptr_inc    = 1'b1;
                        state_next     = ST_INS;
                    end
                end
            end

            // ripple the displaced entry upwards
            ST_INS:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wa_sel = WA_PTR;
                ctl.wd_sel = WD_CARRY;
                if (sts.ptr_at_count)
                begin
                    ctl.count_inc    = 1'b1;
                    ctl.mark_changed = 1'b1;
                    state_next       = ST_NEXT;
                end
                else
                begin
                    ctl.carry_load = 1'b1;
                    ctl.rd_en      = 1'b1;
                    ctl.rd_sel     = RD_NEXT;
                    ctl.ptr_inc    = 1'b1;
                end
            end

            // move each later entry down by one
            ST_DEL:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wa_sel = WA_PREV;
                ctl.wd_sel = WD_FETCH;
                if (sts.ptr_last)
                begin
                    ctl.count_dec    = 1'b1;
                    ctl.mark_changed = 1'b1;
                    state_next       = ST_NEXT;
                end
                else
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_sel  = RD_NEXT;
                    ctl.ptr_inc = 1'b1;
                end
            end

            ST_NEXT:
            begin
                if ((sts.func != FUNC_RANGE) || sts.range_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.col_step = 1'b1;
                    state_next   = ST_START;
                end
            end

            ST_READ:
            begin
                ctl.read_take = 1'b1;
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                if (rsp_free)
                begin
                    ctl.rsp_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== rtl/sorted_column_set_update.sv =====
// top level of the sorted column set update block (tab stop list)
// joins the controller scsu_ctrl and the datapath scsu_dp; types from scsu_pkg
//
//  channel  dir  handshake             payload
//  cmd      in   cmd_valid/cmd_stall   scsu_cmd_t: func, set_not_clear, column, end_column,
//                                      interval, read_index
//  rsp      out  rsp_valid/rsp_stall   scsu_rsp_t: stop_total, changed, overflow,
//                                      read_valid, read_column
//
// walk: a single set or clear walks the list memory one entry a cycle (search, then ripple
//   up or down); a range repeats that per column stepped
// reset: asynchronous, clears the stop count and the control; the list contents need none
// stalls: one command is worked at a time; the next transfer is taken while a finished
//   response still waits in its output register
module sorted_column_set_update #(
    parameter int unsigned CAPACITY = scsu_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  scsu_pkg::scsu_cmd_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output scsu_pkg::scsu_rsp_t rsp
);
    import scsu_pkg::*;

    // command and status between controller and datapath
    scsu_ctl_t ctl;
    scsu_sts_t sts;

    // sequencer: owns both handshakes and the walk over the list
    scsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // list memory, count, pointer and response register
    scsu_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctl   (ctl),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
